[rtl/eabb_pkg.sv]
// Shared types, fixed-point constants and helper functions for the ellipse
// arc bounding box pipeline. No dependencies.
`default_nettype none

package eabb_pkg;

  // Lane and datapath widths
  localparam int VW = 50;   // vectoring lane x/y (a*Xd, b*Yd plus gain)
  localparam int ZW = 34;   // CORDIC angle accumulator, Q30
  localparam int RW = 34;   // rotation lane x/y, Q2.30
  localparam int PW = 38;   // evaluated point coordinate
  localparam int NRED = 10; // values reduced modulo 2*pi per word

  // Angle constants, Q7.24
  localparam logic [26:0]        TWO_PI   = 27'd105414357;
  localparam logic signed [33:0] TWO_PI_S = 34'sd105414357;
  localparam logic signed [33:0] PI_S     = 34'sd52707179;
  localparam logic signed [33:0] HALF_S   = 34'sd26353589;
  // 21 turns: lifts any 32-bit angle difference above zero
  localparam logic signed [34:0] OFFSET_S = 35'sd2213701497;
  // floor(2^50 / TWO_PI), quotient estimate that is low by at most one
  localparam logic [23:0]        RECIP    = 24'd10680707;

  // CORDIC gain, Q30
  localparam logic [29:0]          GAIN   = 30'd652032874;
  localparam logic signed [RW-1:0] GAIN_S = 34'sd652032874;

  typedef struct packed {
    logic signed [VW-1:0] x;
    logic signed [VW-1:0] y;
    logic signed [ZW-1:0] z;
  } vec_lane_t;

  typedef struct packed {
    logic signed [RW-1:0] x;
    logic signed [RW-1:0] y;
    logic signed [ZW-1:0] z;
  } rot_lane_t;

  // Per-word context that travels down the pipe
  typedef struct packed {
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic [30:0]        ra;
    logic [30:0]        rb;
    logic signed [15:0] xdx;
    logic signed [15:0] xdy;
    logic signed [15:0] ydx;
    logic signed [15:0] ydy;
    logic signed [31:0] u1;
    logic signed [31:0] u2;
    logic               full;
    logic [1:0]         xdz;
    logic [1:0]         use_ax;
    logic [5:0]         neg;
    logic [3:0]         inc;
    logic [1:0][34:0]   amp;
  } ctx_t;

  typedef struct packed {
    logic                 v;
    logic signed [PW-1:0] lox;
    logic signed [PW-1:0] hix;
    logic signed [PW-1:0] loy;
    logic signed [PW-1:0] hiy;
  } box_t;

  typedef struct packed {
    logic signed [31:0] min_x;
    logic signed [31:0] min_y;
    logic signed [31:0] max_x;
    logic signed [31:0] max_y;
  } res_t;

  // atan(2^-k) in Q30
  function automatic logic signed [ZW-1:0] atan_q30(input logic [4:0] k);
    logic signed [ZW-1:0] r;
    case (k)
      5'd0:  r = 34'sd843314857;
      5'd1:  r = 34'sd497837829;
      5'd2:  r = 34'sd263043837;
      5'd3:  r = 34'sd133525159;
      5'd4:  r = 34'sd67021687;
      5'd5:  r = 34'sd33543516;
      5'd6:  r = 34'sd16775851;
      5'd7:  r = 34'sd8388437;
      5'd8:  r = 34'sd4194283;
      5'd9:  r = 34'sd2097149;
      5'd10: r = 34'sd1048576;
      5'd11: r = 34'sd524288;
      5'd12: r = 34'sd262144;
      5'd13: r = 34'sd131072;
      5'd14: r = 34'sd65536;
      5'd15: r = 34'sd32768;
      5'd16: r = 34'sd16384;
      5'd17: r = 34'sd8192;
      5'd18: r = 34'sd4096;
      5'd19: r = 34'sd2048;
      5'd20: r = 34'sd1024;
      5'd21: r = 34'sd512;
      5'd22: r = 34'sd256;
      5'd23: r = 34'sd128;
      5'd24: r = 34'sd64;
      5'd25: r = 34'sd32;
      5'd26: r = 34'sd16;
      5'd27: r = 34'sd8;
      5'd28: r = 34'sd4;
      5'd29: r = 34'sd2;
      5'd30: r = 34'sd1;
      default: r = '0;
    endcase
    return r;
  endfunction

  // Union of two boxes; an invalid side contributes nothing
  function automatic box_t box_merge(input box_t a, input box_t b);
    box_t r;
    if (!a.v) begin
      r = b;
    end else if (!b.v) begin
      r = a;
    end else begin
      r.v   = 1'b1;
      r.lox = (b.lox < a.lox) ? b.lox : a.lox;
      r.hix = (b.hix > a.hix) ? b.hix : a.hix;
      r.loy = (b.loy < a.loy) ? b.loy : a.loy;
      r.hiy = (b.hiy > a.hiy) ? b.hiy : a.hiy;
    end
    return r;
  endfunction

  // Clamp to the signed 32-bit range
  function automatic logic signed [31:0] sat32(input logic signed [38:0] v);
    logic signed [31:0] r;
    if (v > 39'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -39'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = 32'(v);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[rtl/ellipse_arc_bounding_box.sv]
// Ellipse arc bounding box: one ellipse word in, one box word out.
// Depends on eabb_pkg, eabb_vec_cell and eabb_rot_cell.
//
// Takes one ellipse word per clock and returns its axis-aligned box widened
// by the tolerance register. A row of CORDIC_STAGES vectoring cells finds
// the extremal angles and amplitudes, then a row of CORDIC_STAGES rotation
// cells evaluates sine and cosine for both endpoints and the four extremal
// angles side by side, and about a dozen stages of multiply, reduce and
// min/max surround them. A full pipeline sustains one word per cycle; a
// stalled output is caught in a one-word skid register, after which
// in_ready drops until it drains.
`default_nettype none

module ellipse_arc_bounding_box import eabb_pkg::*; #(
  parameter int CORDIC_STAGES = 24
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [30:0]        tolerance,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] center_x,
  input  logic signed [31:0] center_y,
  input  logic [30:0]        major_radius,
  input  logic [30:0]        minor_radius,
  input  logic signed [15:0] xaxis_dir_x,
  input  logic signed [15:0] xaxis_dir_y,
  input  logic signed [15:0] yaxis_dir_x,
  input  logic signed [15:0] yaxis_dir_y,
  input  logic signed [31:0] start_angle,
  input  logic signed [31:0] end_angle,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] box_min_x,
  output logic signed [31:0] box_min_y,
  output logic signed [31:0] box_max_x,
  output logic signed [31:0] box_max_y
);

  localparam int NS     = CORDIC_STAGES;
  localparam int IDX_S1 = 1;
  localparam int IDX_S2 = NS + 2;
  localparam int IDX_S3 = NS + 3;
  localparam int IDX_S4 = NS + 4;
  localparam int IDX_S5 = NS + 5;
  localparam int IDX_S6 = NS + 6;
  localparam int IDX_S7 = 2 * NS + 7;
  localparam int IDX_S8 = 2 * NS + 8;
  localparam int IDX_S9 = 2 * NS + 9;
  localparam int IDX_SA = 2 * NS + 10;
  localparam int NP     = 2 * NS + 13;

  // Configuration
  logic [30:0] tol;

  // Pipe control
  logic          en;
  logic [NP-1:0] vld;
  ctx_t          ctx_p  [NP];
  ctx_t          ctx_nx [NP];
  ctx_t          ctx_in;

  // Stage payloads
  vec_lane_t            vl0      [2];
  vec_lane_t            vl0_next [2];
  vec_lane_t            vl       [NS][2];
  logic [1:0]           xdz_next;
  logic [1:0]           use_next;
  logic                 full_next;
  logic [32:0]          red_v      [NRED];
  logic [32:0]          red_v_next [NRED];
  logic [35:0]          mag14      [2];
  logic [35:0]          mag14_next [2];
  logic [6:0]           red_q      [NRED];
  logic [6:0]           red_q_next [NRED];
  logic [32:0]          red_v3     [NRED];
  logic [1:0][34:0]     amp_next;
  logic [27:0]          red_r      [NRED];
  logic [27:0]          red_r_next [NRED];
  logic [26:0]          red_m      [NRED];
  logic [26:0]          red_m_next [NRED];
  rot_lane_t            rl0      [6];
  rot_lane_t            rl0_next [6];
  rot_lane_t            rl       [NS][6];
  logic [5:0]           neg_next;
  logic [3:0]           inc_next;
  logic signed [33:0]   ac      [6];
  logic signed [33:0]   bs      [6];
  logic signed [33:0]   ac_next [6];
  logic signed [33:0]   bs_next [6];
  logic signed [35:0]   axx [6];
  logic signed [35:0]   axy [6];
  logic signed [35:0]   byx [6];
  logic signed [35:0]   byy [6];
  logic signed [35:0]   axx_next [6];
  logic signed [35:0]   axy_next [6];
  logic signed [35:0]   byx_next [6];
  logic signed [35:0]   byy_next [6];
  logic signed [PW-1:0] ptx [6];
  logic signed [PW-1:0] pty [6];
  logic signed [PW-1:0] ptx_next [6];
  logic signed [PW-1:0] pty_next [6];
  box_t                 grp      [3];
  box_t                 grp_next [3];
  box_t                 fin;
  box_t                 fin_next;
  res_t                 res;
  res_t                 res_next;

  // Output register and skid
  logic ov;
  logic sv;
  res_t odata;
  res_t sdata;

  // Configuration port: always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      tol <= '0;
    end else if (cfg_valid) begin
      tol <= tolerance;
    end
  end

  // Advance the whole pipe unless the skid holds a word
  assign en       = !sv;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NP-2:0], in_valid & in_ready};
    end
  end

  // Input word into the context
  always_comb begin
    ctx_in      = '0;
    ctx_in.cx   = center_x;
    ctx_in.cy   = center_y;
    ctx_in.ra   = major_radius;
    ctx_in.rb   = minor_radius;
    ctx_in.xdx  = xaxis_dir_x;
    ctx_in.xdy  = xaxis_dir_y;
    ctx_in.ydx  = yaxis_dir_x;
    ctx_in.ydy  = yaxis_dir_y;
    ctx_in.u1   = start_angle;
    ctx_in.u2   = end_angle;
  end

  // Context moves one stage a cycle while en is high; a few stages fill in fields
  always_comb begin
    ctx_nx[0] = ctx_in;
    for (int i = 1; i < NP; i++) begin
      ctx_nx[i] = ctx_p[i-1];
    end
    ctx_nx[IDX_S1].full   = full_next;
    ctx_nx[IDX_S1].xdz    = xdz_next;
    ctx_nx[IDX_S1].use_ax = use_next;
    ctx_nx[IDX_S3].amp    = amp_next;
    ctx_nx[IDX_S6].neg    = neg_next;
    ctx_nx[IDX_S6].inc    = inc_next;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NP; i++) begin
        ctx_p[i] <= ctx_nx[i];
      end
    end
  end

  // Stage 1: axis products, fold into the right half plane, flags
  always_comb begin
    logic signed [47:0] p;
    logic signed [47:0] q;
    logic signed [VW-1:0] px;
    logic signed [VW-1:0] qx;
    logic signed [15:0] xd;
    logic signed [15:0] yd;
    logic signed [33:0] du;
    for (int k = 0; k < 2; k++) begin
      xd = (k == 0) ? ctx_p[0].xdx : ctx_p[0].xdy;
      yd = (k == 0) ? ctx_p[0].ydx : ctx_p[0].ydy;
      p  = $signed({1'b0, ctx_p[0].ra}) * xd;
      q  = $signed({1'b0, ctx_p[0].rb}) * yd;
      px = VW'(p);
      qx = VW'(q);
      vl0_next[k].x = (px < 0) ? -px : px;
      vl0_next[k].y = (px < 0) ? -qx : qx;
      vl0_next[k].z = '0;
      xdz_next[k]   = (xd == 0);
      use_next[k]   = (xd == 0) || (p != 0) || (q != 0);
    end
    du        = 34'(ctx_p[0].u2) - 34'(ctx_p[0].u1);
    full_next = (du >= TWO_PI_S);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vl0 <= vl0_next;
    end
  end

  // Vectoring row, one cell per iteration and axis
  for (genvar gi = 0; gi < NS; gi++) begin : g_vec
    for (genvar gk = 0; gk < 2; gk++) begin : g_ax
      if (gi == 0) begin : g_first
        eabb_vec_cell #(.STAGE(gi)) u_cell (
          .clk      (clk),
          .en       (en),
          .lane_in  (vl0[gk]),
          .lane_out (vl[gi][gk])
        );
      end else begin : g_rest
        eabb_vec_cell #(.STAGE(gi)) u_cell (
          .clk      (clk),
          .en       (en),
          .lane_in  (vl[gi-1][gk]),
          .lane_out (vl[gi][gk])
        );
      end
    end
  end

  // Stage 2: extremal angles, rounded magnitudes, offset values for the mod-2pi reduction
  always_comb begin
    logic signed [ZW-1:0] tr;
    logic signed [33:0]   t0;
    logic signed [33:0]   t1;
    logic signed [34:0]   u1e;
    logic signed [34:0]   u2e;
    logic signed [34:0]   tv;
    logic signed [VW-1:0] mr;
    u1e = 35'(ctx_p[IDX_S2-1].u1);
    u2e = 35'(ctx_p[IDX_S2-1].u2);
    red_v_next[0] = 33'(u1e + OFFSET_S);
    red_v_next[1] = 33'(u2e + OFFSET_S);
    for (int k = 0; k < 2; k++) begin
      tr = (vl[NS-1][k].z + 34'sd32) >>> 6;
      if (ctx_p[IDX_S2-1].xdz[k]) begin
        t0 = HALF_S;
      end else if (tr < 0) begin
        t0 = tr + TWO_PI_S;
      end else begin
        t0 = tr;
      end
      t1 = (t0 <= PI_S) ? t0 + PI_S : t0 - PI_S;
      tv = 35'(t0);
      red_v_next[2 + 2*k]     = 33'(tv + OFFSET_S);
      red_v_next[6 + 2*k]     = 33'(tv - u1e + OFFSET_S);
      tv = 35'(t1);
      red_v_next[3 + 2*k]     = 33'(tv + OFFSET_S);
      red_v_next[7 + 2*k]     = 33'(tv - u1e + OFFSET_S);
      mr = (vl[NS-1][k].x + 50'sd8192) >>> 14;
      mag14_next[k] = 36'(mr);
    end
  end

  // Stage 3: quotient estimate, amplitude scaling
  always_comb begin
    logic [46:0] qp;
    logic [65:0] mp;
    for (int i = 0; i < NRED; i++) begin
      qp = 47'(red_v[i][32:10]) * 47'(RECIP);
      red_q_next[i] = qp[46:40];
    end
    for (int k = 0; k < 2; k++) begin
      mp = 66'(mag14[k]) * 66'(GAIN);
      amp_next[k] = 35'((mp + 66'd536870912) >> 30);
    end
  end

  // Stage 4: subtract the estimated turns
  always_comb begin
    logic [33:0] qm;
    logic [33:0] r;
    for (int i = 0; i < NRED; i++) begin
      qm = 34'(red_q[i]) * 34'(TWO_PI);
      r  = 34'(red_v3[i]) - qm;
      red_r_next[i] = r[27:0];
    end
  end

  // Stage 5: final correction into [0, 2pi)
  always_comb begin
    for (int i = 0; i < NRED; i++) begin
      if (red_r[i] >= 28'(TWO_PI)) begin
        red_m_next[i] = 27'(red_r[i] - 28'(TWO_PI));
      end else begin
        red_m_next[i] = red_r[i][26:0];
      end
    end
  end

  // Stage 6: fold angles to +/- pi/2, test extremal angles against the arc
  always_comb begin
    logic signed [33:0] ms;
    logic signed [33:0] rr;
    logic signed [33:0] lhs;
    for (int i = 0; i < 6; i++) begin
      ms = $signed(34'(red_m[i]));
      rr = (ms > PI_S) ? ms - TWO_PI_S : ms;
      if (rr > HALF_S) begin
        rr          = rr - PI_S;
        neg_next[i] = 1'b1;
      end else if (rr < -HALF_S) begin
        rr          = rr + PI_S;
        neg_next[i] = 1'b1;
      end else begin
        neg_next[i] = 1'b0;
      end
      rl0_next[i].x = GAIN_S;
      rl0_next[i].y = '0;
      rl0_next[i].z = rr <<< 6;
    end
    for (int j = 0; j < 4; j++) begin
      lhs = 34'(ctx_p[IDX_S6-1].u1) + $signed(34'(red_m[6 + j]));
      inc_next[j] = (lhs <= 34'(ctx_p[IDX_S6-1].u2)) && ctx_p[IDX_S6-1].use_ax[j / 2];
    end
  end

  // Reduction and fold registers
  always_ff @(posedge clk) begin
    if (en) begin
      red_v  <= red_v_next;
      mag14  <= mag14_next;
      red_q  <= red_q_next;
      red_v3 <= red_v;
      red_r  <= red_r_next;
      red_m  <= red_m_next;
      rl0    <= rl0_next;
    end
  end

  // Rotation row: endpoints and four extremal angles side by side
  for (genvar gi = 0; gi < NS; gi++) begin : g_rot
    for (genvar gl = 0; gl < 6; gl++) begin : g_lane
      if (gi == 0) begin : g_first
        eabb_rot_cell #(.STAGE(gi)) u_cell (
          .clk      (clk),
          .en       (en),
          .lane_in  (rl0[gl]),
          .lane_out (rl[gi][gl])
        );
      end else begin : g_rest
        eabb_rot_cell #(.STAGE(gi)) u_cell (
          .clk      (clk),
          .en       (en),
          .lane_in  (rl[gi-1][gl]),
          .lane_out (rl[gi][gl])
        );
      end
    end
  end

  // Stage 7: scale cosine and sine by the radii
  always_comb begin
    logic signed [RW-1:0] cs;
    logic signed [RW-1:0] sn;
    logic signed [63:0]   pa;
    logic signed [63:0]   pb;
    for (int l = 0; l < 6; l++) begin
      cs = ctx_p[IDX_S7-1].neg[l] ? -rl[NS-1][l].x : rl[NS-1][l].x;
      sn = ctx_p[IDX_S7-1].neg[l] ? -rl[NS-1][l].y : rl[NS-1][l].y;
      pa = $signed({1'b0, ctx_p[IDX_S7-1].ra}) * $signed(32'(cs));
      pb = $signed({1'b0, ctx_p[IDX_S7-1].rb}) * $signed(32'(sn));
      ac_next[l] = 34'((pa + 64'sd536870912) >>> 30);
      bs_next[l] = 34'((pb + 64'sd536870912) >>> 30);
    end
  end

  // Stage 8: project onto the axis directions
  always_comb begin
    logic signed [49:0] pr;
    for (int l = 0; l < 6; l++) begin
      pr = ac[l] * ctx_p[IDX_S8-1].xdx;
      axx_next[l] = 36'((pr + 50'sd8192) >>> 14);
      pr = ac[l] * ctx_p[IDX_S8-1].xdy;
      axy_next[l] = 36'((pr + 50'sd8192) >>> 14);
      pr = bs[l] * ctx_p[IDX_S8-1].ydx;
      byx_next[l] = 36'((pr + 50'sd8192) >>> 14);
      pr = bs[l] * ctx_p[IDX_S8-1].ydy;
      byy_next[l] = 36'((pr + 50'sd8192) >>> 14);
    end
  end

  // Stage 9: add the center
  always_comb begin
    for (int l = 0; l < 6; l++) begin
      ptx_next[l] = PW'(ctx_p[IDX_S9-1].cx) + PW'(axx[l]) + PW'(byx[l]);
      pty_next[l] = PW'(ctx_p[IDX_S9-1].cy) + PW'(axy[l]) + PW'(byy[l]);
    end
  end

  // Stage 10: merge point pairs
  always_comb begin
    box_t pb [6];
    for (int l = 0; l < 6; l++) begin
      pb[l].v   = (l < 2) ? 1'b1 : ctx_p[IDX_SA-1].inc[l - 2];
      pb[l].lox = ptx[l];
      pb[l].hix = ptx[l];
      pb[l].loy = pty[l];
      pb[l].hiy = pty[l];
    end
    for (int g = 0; g < 3; g++) begin
      grp_next[g] = box_merge(pb[2*g], pb[2*g + 1]);
    end
  end

  // Stage 11: merge groups, or take the full-turn extent
  always_comb begin
    box_t bb;
    ctx_t c;
    c  = ctx_p[IDX_SA];
    bb = box_merge(box_merge(grp[0], grp[1]), grp[2]);
    if (c.full) begin
      fin_next.v   = 1'b1;
      fin_next.lox = PW'(c.cx) - $signed(PW'(c.amp[0]));
      fin_next.hix = PW'(c.cx) + $signed(PW'(c.amp[0]));
      fin_next.loy = PW'(c.cy) - $signed(PW'(c.amp[1]));
      fin_next.hiy = PW'(c.cy) + $signed(PW'(c.amp[1]));
    end else begin
      fin_next = bb;
    end
  end

  // Stage 12: widen by the tolerance and saturate
  always_comb begin
    logic signed [38:0] t;
    t = $signed({8'b0, tol});
    res_next.min_x = sat32(39'(fin.lox) - t);
    res_next.min_y = sat32(39'(fin.loy) - t);
    res_next.max_x = sat32(39'(fin.hix) + t);
    res_next.max_y = sat32(39'(fin.hiy) + t);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ac  <= ac_next;
      bs  <= bs_next;
      axx <= axx_next;
      axy <= axy_next;
      byx <= byx_next;
      byy <= byy_next;
      ptx <= ptx_next;
      pty <= pty_next;
      grp <= grp_next;
      fin <= fin_next;
      res <= res_next;
    end
  end

  // Output register with a one-word skid behind it
  always_ff @(posedge clk) begin
    logic incoming;
    logic out_free;
    incoming = en && vld[NP-1];
    out_free = !ov || out_ready;
    if (rst) begin
      ov <= 1'b0;
      sv <= 1'b0;
    end else if (out_free) begin
      if (sv) begin
        ov    <= 1'b1;
        odata <= sdata;
        sv    <= 1'b0;
      end else if (incoming) begin
        ov    <= 1'b1;
        odata <= res;
      end else begin
        ov <= 1'b0;
      end
    end else if (incoming) begin
      sv    <= 1'b1;
      sdata <= res;
    end
  end

  assign out_valid = ov;
  assign box_min_x = odata.min_x;
  assign box_min_y = odata.min_y;
  assign box_max_x = odata.max_x;
  assign box_max_y = odata.max_y;

  // The skid only holds a word while the output register is full
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    sv |-> ov)
    else $error("skid holds a word while output register is empty");

  // A word leaving the pipe into a stalled output is caught by the skid
  a_skid_catches: assert property (@(posedge clk) disable iff (rst)
    (ov && !out_ready && vld[NP-1] && en) |=> sv)
    else $error("word from the pipe lost at a stalled output");

  // The skid fills only on an output stall
  a_skid_fill_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(sv) |-> $past(ov && !out_ready))
    else $error("skid filled without an output stall");

endmodule

`default_nettype wire

[rtl/eabb_vec_cell.sv]
// One vectoring CORDIC stage: drives y toward zero and sums the angle.
// Depends on eabb_pkg.
`default_nettype none

module eabb_vec_cell import eabb_pkg::*; #(
  parameter int STAGE = 0
) (
  input  logic      clk,
  input  logic      en,
  input  vec_lane_t lane_in,
  output vec_lane_t lane_out
);

  localparam logic [4:0] K = 5'(STAGE);

  logic signed [VW-1:0] dx;
  logic signed [VW-1:0] dy;
  logic signed [ZW-1:0] da;
  vec_lane_t            lane_next;

  // Rotate by +/- atan(2^-K) depending on the sign of y
  always_comb begin
    dx = lane_in.y >>> K;
    dy = lane_in.x >>> K;
    da = atan_q30(K);
    if (lane_in.y >= 0) begin
      lane_next.x = lane_in.x + dx;
      lane_next.y = lane_in.y - dy;
      lane_next.z = lane_in.z + da;
    end else begin
      lane_next.x = lane_in.x - dx;
      lane_next.y = lane_in.y + dy;
      lane_next.z = lane_in.z - da;
    end
  end

  // Hand the lane to the next cell
  always_ff @(posedge clk) begin
    if (en) begin
      lane_out <= lane_next;
    end
  end

endmodule

`default_nettype wire

[rtl/eabb_rot_cell.sv]
// One rotation CORDIC stage: drives the residual angle toward zero.
// Depends on eabb_pkg.
`default_nettype none

module eabb_rot_cell import eabb_pkg::*; #(
  parameter int STAGE = 0
) (
  input  logic      clk,
  input  logic      en,
  input  rot_lane_t lane_in,
  output rot_lane_t lane_out
);

  localparam logic [4:0] K = 5'(STAGE);

  logic signed [RW-1:0] dx;
  logic signed [RW-1:0] dy;
  logic signed [ZW-1:0] da;
  rot_lane_t            lane_next;

  // Rotate by +/- atan(2^-K) depending on the sign of z
  always_comb begin
    dx = lane_in.y >>> K;
    dy = lane_in.x >>> K;
    da = atan_q30(K);
    if (lane_in.z >= 0) begin
      lane_next.x = lane_in.x - dx;
      lane_next.y = lane_in.y + dy;
      lane_next.z = lane_in.z - da;
    end else begin
      lane_next.x = lane_in.x + dx;
      lane_next.y = lane_in.y - dy;
      lane_next.z = lane_in.z + da;
    end
  end

  // Hand the lane to the next cell
  always_ff @(posedge clk) begin
    if (en) begin
      lane_out <= lane_next;
    end
  end

endmodule

`default_nettype wire

[tb/tb.sv]
// Self-checking bench for ellipse_arc_bounding_box: random and directed ellipse
// words, a bit-exact fixed-point box predictor, and random stalls on both sides.
// Depends on rtl/eabb_pkg.sv and rtl/ellipse_arc_bounding_box.sv.
`timescale 1ns / 100ps

module tb import eabb_pkg::*; ();

  localparam int     STAGES     = 24;
  localparam longint TURN       = 105414357;
  localparam longint HALF_TURN  = 52707179;
  localparam longint QTR_TURN   = 26353589;
  localparam longint K_GAIN     = 652032874;
  localparam int     SETTLE     = 2 * STAGES + 40;
  localparam longint CYCLE_CAP  = 600000;
  localparam int     RAND_WORDS = 1100;

  localparam longint ATAN_TAB [32] = '{
    843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
    16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072,
    65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32,
    16, 8, 4, 2, 1, 0};

  typedef struct packed {
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic [30:0]        ra;
    logic [30:0]        rb;
    logic signed [15:0] xdx;
    logic signed [15:0] xdy;
    logic signed [15:0] ydx;
    logic signed [15:0] ydy;
    logic signed [31:0] u1;
    logic signed [31:0] u2;
  } ellipse_t;

  logic clk;
  logic rst;
  logic cfg_valid;
  logic cfg_ready;
  logic [30:0] tolerance;
  logic in_valid;
  logic in_ready;
  logic out_valid;
  logic out_ready;
  logic signed [31:0] box_min_x, box_min_y, box_max_x, box_max_y;
  ellipse_t drv_word;

  ellipse_t ellipse_q[$];
  res_t     box_q[$];
  logic [30:0] margin;
  longint cycles;
  int     mismatches;
  int     boxes_seen;
  int     words_sent;
  int     send_gap;
  int     recv_gap;
  int     hold_left;
  bit     hold_done;
  bit     calm;

  ellipse_arc_bounding_box #(.CORDIC_STAGES(STAGES)) dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .tolerance(tolerance),
    .in_valid(in_valid), .in_ready(in_ready),
    .center_x(drv_word.cx), .center_y(drv_word.cy),
    .major_radius(drv_word.ra), .minor_radius(drv_word.rb),
    .xaxis_dir_x(drv_word.xdx), .xaxis_dir_y(drv_word.xdy),
    .yaxis_dir_x(drv_word.ydx), .yaxis_dir_y(drv_word.ydy),
    .start_angle(drv_word.u1), .end_angle(drv_word.u2),
    .out_valid(out_valid), .out_ready(out_ready),
    .box_min_x(box_min_x), .box_min_y(box_min_y),
    .box_max_x(box_max_x), .box_max_y(box_max_y)
  );

  // ---------------- box predictor ----------------

  function automatic longint round_shift(longint v, int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic void rotate_sincos(longint t, output longint c, output longint s);
    longint r, x, y, z, dx, dy;
    bit flip;
    int k;
    flip = 1'b0;
    r = t % TURN;
    if (r < 0) r += TURN;
    if (r > HALF_TURN) r -= TURN;
    if (r > QTR_TURN) begin
      r -= HALF_TURN;
      flip = 1'b1;
    end else if (r < -QTR_TURN) begin
      r += HALF_TURN;
      flip = 1'b1;
    end
    x = K_GAIN;
    y = 0;
    z = r * 64;
    for (int i = 0; i < STAGES; i++) begin
      k = i & 31;
      dx = y >>> k;
      dy = x >>> k;
      if (z >= 0) begin
        x -= dx; y += dy; z -= ATAN_TAB[k];
      end else begin
        x += dx; y -= dy; z += ATAN_TAB[k];
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  function automatic void vector_angle(longint p, longint q, output longint ang,
                                       output longint mag);
    longint x, y, z, dx, dy;
    int k;
    x = p;
    y = q;
    z = 0;
    if (x < 0) begin
      x = -x; y = -y;
    end
    for (int i = 0; i < STAGES; i++) begin
      k = i & 31;
      dx = y >>> k;
      dy = x >>> k;
      if (y >= 0) begin
        x += dx; y -= dy; z += ATAN_TAB[k];
      end else begin
        x -= dx; y += dy; z -= ATAN_TAB[k];
      end
    end
    ang = z;
    mag = x;
  endfunction

  // Point on the ellipse at parameter t
  function automatic void arc_point(longint t, longint a, longint b, ellipse_t e,
                                    output longint px, output longint py);
    longint cs, sn, ac, bs;
    rotate_sincos(t, cs, sn);
    ac = round_shift(a * cs, 30);
    bs = round_shift(b * sn, 30);
    px = longint'(e.cx) + round_shift(ac * longint'(e.xdx), 14)
         + round_shift(bs * longint'(e.ydx), 14);
    py = longint'(e.cy) + round_shift(ac * longint'(e.xdy), 14)
         + round_shift(bs * longint'(e.ydy), 14);
  endfunction

  function automatic logic signed [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic res_t predict_box(ellipse_t e, logic [30:0] tol);
    longint a, b, u1, u2, lo[2], hi[2], px, py, xd, yd, cen, ang, mag, amp, m;
    longint tt[2];
    res_t r;
    a = longint'({1'b0, e.ra});
    b = longint'({1'b0, e.rb});
    u1 = longint'(e.u1);
    u2 = longint'(e.u2);
    if (u2 - u1 >= TURN) begin
      // full turn: amplitude along each axis
      for (int k = 0; k < 2; k++) begin
        xd = (k == 0) ? longint'(e.xdx) : longint'(e.xdy);
        yd = (k == 0) ? longint'(e.ydx) : longint'(e.ydy);
        cen = (k == 0) ? longint'(e.cx) : longint'(e.cy);
        vector_angle(a * xd, b * yd, ang, mag);
        amp = round_shift(round_shift(mag, 14) * K_GAIN, 30);
        lo[k] = cen - amp;
        hi[k] = cen + amp;
      end
    end else begin
      arc_point(u1, a, b, e, px, py);
      lo[0] = px; hi[0] = px; lo[1] = py; hi[1] = py;
      arc_point(u2, a, b, e, px, py);
      if (px < lo[0]) lo[0] = px;
      if (px > hi[0]) hi[0] = px;
      if (py < lo[1]) lo[1] = py;
      if (py > hi[1]) hi[1] = py;
      // extremal parameters per axis and their opposites
      for (int k = 0; k < 2; k++) begin
        xd = (k == 0) ? longint'(e.xdx) : longint'(e.xdy);
        yd = (k == 0) ? longint'(e.ydx) : longint'(e.ydy);
        if (xd == 0) begin
          tt[0] = QTR_TURN;
        end else begin
          if (a * xd == 0 && b * yd == 0) continue;
          vector_angle(a * xd, b * yd, ang, mag);
          tt[0] = round_shift(ang, 6);
          if (tt[0] < 0) tt[0] += TURN;
        end
        tt[1] = (tt[0] <= HALF_TURN) ? tt[0] + HALF_TURN : tt[0] - HALF_TURN;
        for (int j = 0; j < 2; j++) begin
          m = (tt[j] - u1) % TURN;
          if (m < 0) m += TURN;
          if (u1 + m <= u2) begin
            arc_point(tt[j], a, b, e, px, py);
            if (px < lo[0]) lo[0] = px;
            if (px > hi[0]) hi[0] = px;
            if (py < lo[1]) lo[1] = py;
            if (py > hi[1]) hi[1] = py;
          end
        end
      end
    end
    r.min_x = clamp32(lo[0] - longint'({1'b0, tol}));
    r.min_y = clamp32(lo[1] - longint'({1'b0, tol}));
    r.max_x = clamp32(hi[0] + longint'({1'b0, tol}));
    r.max_y = clamp32(hi[1] + longint'({1'b0, tol}));
    return r;
  endfunction

  // ---------------- stimulus ----------------

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic ellipse_t mk(int cx, int cy, int ra, int rb, int xdx, int xdy,
                                  int ydx, int ydy, int u1, int u2);
    ellipse_t e;
    e.cx = cx; e.cy = cy; e.ra = ra[30:0]; e.rb = rb[30:0];
    e.xdx = xdx[15:0]; e.xdy = xdy[15:0]; e.ydx = ydx[15:0]; e.ydy = ydy[15:0];
    e.u1 = u1; e.u2 = u2;
    return e;
  endfunction

  function automatic ellipse_t rand_ellipse();
    ellipse_t e;
    int kind, sel;
    real th;
    int span;
    kind = $urandom_range(0, 9);
    e.cx = $urandom;
    e.cy = $urandom;
    e.ra = 31'($urandom);
    e.rb = 31'($urandom);
    if (kind < 7) begin
      e.cx = e.cx >>> 8;
      e.cy = e.cy >>> 8;
      e.ra = e.ra >> 9;
      e.rb = e.rb >> ($urandom_range(9, 14));
    end
    if (kind < 8) begin
      // rotated unit axes, either handedness
      th = $urandom_range(0, 62831) / 10000.0;
      e.xdx = 16'($rtoi(16384.0 * $cos(th)));
      e.xdy = 16'($rtoi(16384.0 * $sin(th)));
      e.ydx = $urandom_range(0, 1) ? -e.xdy : e.xdy;
      e.ydy = (e.ydx == -e.xdy) ? e.xdx : -e.xdx;
    end else begin
      e.xdx = 16'($urandom); e.xdy = 16'($urandom);
      e.ydx = 16'($urandom); e.ydy = 16'($urandom);
    end
    e.u1 = $urandom;
    if (kind < 8) e.u1 = e.u1 >>> 4;
    sel = $urandom_range(0, 99);
    if (sel < 70) span = $urandom_range(0, 105414356);
    else if (sel < 85) span = 105414357 + $urandom_range(0, 4) - 2;
    else if (sel < 93) span = $urandom_range(105414357, 300000000);
    else span = $urandom;
    e.u2 = e.u1 + span;
    return e;
  endfunction

  task automatic wait_drained();
    do @(posedge clk); while (ellipse_q.size() != 0 || in_valid || box_q.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Write the margin register; only called while the pipe is empty
  task automatic write_margin(logic [30:0] v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    tolerance <= v;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    margin = v;
    cfg_valid <= 1'b0;
  endtask

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    logic [30:0] margins[5];
    rst = 1'b1;
    cfg_valid = 1'b0;
    tolerance = '0;
    margin = '0;
    calm = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed words: extremes and special cases
    write_margin(31'd0);
    ellipse_q.push_back(mk(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    ellipse_q.push_back(mk(65536, -65536, 655360, 327680, 16384, 0, 0, 16384,
                           0, 105414357));
    ellipse_q.push_back(mk(65536, -65536, 655360, 327680, 16384, 0, 0, 16384,
                           0, 105414356));
    ellipse_q.push_back(mk(0, 0, 655360, 327680, 11585, 11585, -11585, 11585,
                           -20000000, 40000000));
    // end below start: endpoints only
    ellipse_q.push_back(mk(1000, 2000, 655360, 327680, 16384, 0, 0, 16384,
                           40000000, 10000000));
    // axis direction x component zero
    ellipse_q.push_back(mk(0, 0, 655360, 327680, 0, 16384, -16384, 0,
                           0, 90000000));
    // zero vector on one axis: radius zero
    ellipse_q.push_back(mk(0, 0, 0, 327680, 16384, 0, 0, 16384, 0, 90000000));
    ellipse_q.push_back(mk(0, 0, 655360, 0, 16384, 16384, 0, 0, -5, 80000000));
    // saturating corners
    ellipse_q.push_back(mk(32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h7fffffff,
                           16384, -16384, 16384, 16384, 0, 200000000));
    ellipse_q.push_back(mk(32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                           -16384, -16384, -16384, 16384, 32'h80000000, 32'h7fffffff));
    ellipse_q.push_back(mk(-1, -1, 32'h7fffffff, 32'h7fffffff, 32'hffff8000,
                           32'h7fff, 32'h7fff, 32'hffff8000, 32'h7fffffff, 32'h7fffffff));
    ellipse_q.push_back(mk(0, 0, 32'h7fffffff, 1, -16384, 0, 0, -16384,
                           32'h80000000, 32'h80000000));
    ellipse_q.push_back(mk(12345, -54321, 987654, 123456, 16384, 0, 0, 16384,
                           52707179, 52707179));
    ellipse_q.push_back(mk(12345, -54321, 987654, 123456, 16384, 0, 0, 16384,
                           -26353589, 26353589));
    ellipse_q.push_back(mk(0, 0, 987654, 123456, 16384, 0, 0, 16384,
                           -105414357, 105414356));
    ellipse_q.push_back(mk(0, 0, 987654, 123456, 9000, -13000, 13000, 9000,
                           300000000, 350000000));

    // random phases, each with its own margin
    margins[0] = 31'h7fffffff;
    margins[1] = 31'd65536;
    margins[2] = 31'($urandom);
    margins[3] = 31'd0;
    margins[4] = 31'd1;
    for (int p = 0; p < 5; p++) begin
      wait_drained();
      write_margin(margins[p]);
      calm = (p == 2);
      for (int i = 0; i < RAND_WORDS / 5; i++) ellipse_q.push_back(rand_ellipse());
    end
    wait_drained();

    $display("covered %0d ellipse words over six margin settings, %0d boxes checked",
             words_sent, boxes_seen);
    $display("arcs, full turns, wrapped and reversed ranges, saturated bounds");
    if (mismatches == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

  // ---------------- driver ----------------
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      drv_word <= '0;
      send_gap <= 0;
      words_sent <= 0;
    end else begin
      if (in_valid && in_ready) begin
        box_q.push_back(predict_box(drv_word, margin));
        words_sent <= words_sent + 1;
      end
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_valid <= 1'b0;
        end else if (ellipse_q.size() != 0) begin
          drv_word <= ellipse_q.pop_front();
          in_valid <= 1'b1;
          send_gap <= pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------- long hold-off on the output ----------------
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && words_sent >= 400) begin
      hold_left <= 500;
      hold_done <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // ---------------- monitor ----------------
  always @(posedge clk) begin
    res_t want;
    if (rst) begin
      out_ready <= 1'b0;
      recv_gap <= 0;
      mismatches <= 0;
      boxes_seen <= 0;
    end else begin
      if (out_valid && out_ready) begin
        boxes_seen <= boxes_seen + 1;
        if (box_q.size() == 0) begin
          if (mismatches < 10) $display("box with nothing expected at cycle %0d", cycles);
          mismatches <= mismatches + 1;
        end else begin
          want = box_q.pop_front();
          if (want.min_x !== box_min_x || want.min_y !== box_min_y ||
              want.max_x !== box_max_x || want.max_y !== box_max_y) begin
            if (mismatches < 10)
              $display("box %0d: expected %0d %0d %0d %0d got %0d %0d %0d %0d",
                       boxes_seen, want.min_x, want.min_y, want.max_x, want.max_y,
                       box_min_x, box_min_y, box_max_x, box_max_y);
            mismatches <= mismatches + 1;
          end
        end
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        recv_gap <= pick_gap();
      end
    end
  end

  // ---------------- watchdog ----------------
  always @(posedge clk) begin
    if (rst) begin
      cycles <= 0;
    end else begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_CAP) begin
        $display("tb failed");
        $finish;
      end
    end
  end

endmodule
